// File: src/oan_pkg.sv
`timescale 1ns / 1ps

package oan_pkg;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_DRIVE = 2'd2;

  localparam logic [2:0] CFG_SPEED       = 3'd0;
  localparam logic [2:0] CFG_SPIN_DIAG   = 3'd1;
  localparam logic [2:0] CFG_SPIN_SIDE   = 3'd2;
  localparam logic [2:0] CFG_FRONT_CLEAR = 3'd3;
  localparam logic [2:0] CFG_REAR_CLEAR  = 3'd4;
  localparam logic [2:0] CFG_REAR_STOP   = 3'd5;
  localparam logic [2:0] CFG_RETRY_WAIT  = 3'd6;
  localparam logic [2:0] CFG_BACKUP_LIM  = 3'd7;

  localparam logic [9:0] SPEED_MAX = 10'd1000;

  typedef struct packed {
    logic [9:0]  speed_permille;
    logic [15:0] spin_diagonal_ms;
    logic [15:0] spin_side_ms;
    logic [9:0]  front_clear_cm;
    logic [9:0]  rear_clear_cm;
    logic [9:0]  rear_stop_cm;
    logic [15:0] retry_wait_ms;
    logic [15:0] backup_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        autonomous;
    logic        emergency_stop;
    logic        front_stop_zone;
    logic        scan_done;
    logic [9:0]  dist_front_left;
    logic [9:0]  dist_front_right;
    logic [9:0]  dist_left;
    logic [9:0]  dist_right;
    logic [9:0]  dist_rear;
  } item_t;

  typedef struct packed {
    logic               feed_watchdog;
    logic [1:0]         motor_action;
    logic signed [10:0] forward_permille;
    logic signed [10:0] rotate_permille;
    logic               scan_kick;
    logic               advance_sweep;
    logic               center_sensor;
    logic [2:0]         mode;
  } result_t;

endpackage

// File: src/oan_cfg_regs.sv
`timescale 1ns / 1ps

module oan_cfg_regs
  import oan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_permille   <= 10'd500;
      cfg.spin_diagonal_ms <= 16'd300;
      cfg.spin_side_ms     <= 16'd600;
      cfg.front_clear_cm   <= 10'd40;
      cfg.rear_clear_cm    <= 10'd30;
      cfg.rear_stop_cm     <= 10'd15;
      cfg.retry_wait_ms    <= 16'd2000;
      cfg.backup_limit_ms  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SPEED:       cfg.speed_permille   <= cfg_wdata[9:0];
        CFG_SPIN_DIAG:   cfg.spin_diagonal_ms <= cfg_wdata;
        CFG_SPIN_SIDE:   cfg.spin_side_ms     <= cfg_wdata;
        CFG_FRONT_CLEAR: cfg.front_clear_cm   <= cfg_wdata[9:0];
        CFG_REAR_CLEAR:  cfg.rear_clear_cm    <= cfg_wdata[9:0];
        CFG_REAR_STOP:   cfg.rear_stop_cm     <= cfg_wdata[9:0];
        CFG_RETRY_WAIT:  cfg.retry_wait_ms    <= cfg_wdata;
        CFG_BACKUP_LIM:  cfg.backup_limit_ms  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/oan_target.sv
`timescale 1ns / 1ps

module oan_target
  import oan_pkg::*;
(
  input  item_t       item,
  input  cfg_t        cfg,
  output logic        tgt_right,
  output logic [15:0] tgt_dur
);

  logic [3:0][9:0] span;
  logic [9:0]      best;
  logic [15:0]     dur;
  logic            right;

  assign span[0] = item.dist_front_left;
  assign span[1] = item.dist_front_right;
  assign span[2] = item.dist_left;
  assign span[3] = item.dist_right;

  // Strict compare keeps the earliest direction on a tie.
  always_comb begin
    best  = 10'd0;
    dur   = 16'd0;
    right = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (span[i] > best) begin
        best  = span[i];
        right = (i % 2) == 1;
        dur   = (i < 2) ? cfg.spin_diagonal_ms : cfg.spin_side_ms;
      end
    end
    if (best < cfg.front_clear_cm) begin
      tgt_right = 1'b0;
      tgt_dur   = 16'd0;
    end else begin
      tgt_right = right;
      tgt_dur   = dur;
    end
  end

endmodule

// File: src/oan_core.sv
`timescale 1ns / 1ps

module oan_core
  import oan_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  typedef enum logic [2:0] {
    MOVING   = 3'd0,
    SCANNING = 3'd1,
    SPINNING = 3'd2,
    BACKING  = 3'd3,
    STUCK    = 3'd4
  } nav_mode_t;

  nav_mode_t   nav_mode;
  nav_mode_t   nav_mode_next;
  logic [31:0] entry_time;
  logic [31:0] entry_time_next;
  logic        spin_right;
  logic        spin_right_next;
  logic [15:0] spin_duration;
  logic [15:0] spin_duration_next;
  result_t     res_next;

  logic               tgt_right;
  logic [15:0]        tgt_dur;
  logic [31:0]        elapsed;
  logic [9:0]         spd;
  logic signed [10:0] spd_s;

  oan_target u_target (
    .item      (item),
    .cfg       (cfg),
    .tgt_right (tgt_right),
    .tgt_dur   (tgt_dur)
  );

  assign elapsed = item.now_ms - entry_time;
  assign spd     = (cfg.speed_permille > SPEED_MAX) ? SPEED_MAX : cfg.speed_permille;
  assign spd_s   = signed'({1'b0, spd});

  always_comb begin
    nav_mode_next      = nav_mode;
    entry_time_next    = entry_time;
    spin_right_next    = spin_right;
    spin_duration_next = spin_duration;
    res_next           = '0;
    res_next.motor_action = ACT_NONE;
    if (item.autonomous) begin
      res_next.feed_watchdog = 1'b1;
      if (item.emergency_stop) begin
        res_next.motor_action = ACT_STOP;
      end else begin
        case (nav_mode)
          SCANNING: begin
            res_next.advance_sweep = 1'b1;
            if (item.scan_done) begin
              spin_right_next    = tgt_right;
              spin_duration_next = tgt_dur;
              entry_time_next    = item.now_ms;
              if (tgt_dur != 16'd0) begin
                res_next.center_sensor = 1'b1;
                nav_mode_next = SPINNING;
              end else if (item.dist_rear > cfg.rear_clear_cm) begin
                nav_mode_next = BACKING;
              end else begin
                nav_mode_next = STUCK;
              end
            end
          end
          SPINNING: begin
            if (elapsed >= {16'd0, spin_duration}) begin
              res_next.motor_action = ACT_STOP;
              nav_mode_next   = MOVING;
              entry_time_next = item.now_ms;
            end else begin
              res_next.motor_action    = ACT_DRIVE;
              res_next.rotate_permille = spin_right ? spd_s : -spd_s;
            end
          end
          BACKING: begin
            if (elapsed >= {16'd0, cfg.backup_limit_ms} ||
                item.dist_rear <= cfg.rear_stop_cm) begin
              res_next.motor_action = ACT_STOP;
              res_next.scan_kick    = 1'b1;
              nav_mode_next   = SCANNING;
              entry_time_next = item.now_ms;
            end else begin
              res_next.motor_action     = ACT_DRIVE;
              res_next.forward_permille = -spd_s;
            end
          end
          STUCK: begin
            res_next.motor_action = ACT_STOP;
            if (elapsed >= {16'd0, cfg.retry_wait_ms}) begin
              res_next.scan_kick = 1'b1;
              nav_mode_next   = SCANNING;
              entry_time_next = item.now_ms;
            end
          end
          default: begin
            if (item.front_stop_zone) begin
              res_next.motor_action = ACT_STOP;
              res_next.scan_kick    = 1'b1;
              nav_mode_next   = SCANNING;
              entry_time_next = item.now_ms;
            end else begin
              res_next.motor_action     = ACT_DRIVE;
              res_next.forward_permille = spd_s;
            end
          end
        endcase
      end
    end
    res_next.mode = nav_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nav_mode      <= MOVING;
      entry_time    <= 32'd0;
      spin_right    <= 1'b0;
      spin_duration <= 16'd0;
    end else if (fire) begin
      nav_mode      <= nav_mode_next;
      entry_time    <= entry_time_next;
      spin_right    <= spin_right_next;
      spin_duration <= spin_duration_next;
      res           <= res_next;
    end
  end

endmodule

// File: src/obstacle_avoid_nav_fsm_top.sv
`timescale 1ns / 1ps

// Navigation controller for an obstacle-avoiding vehicle. Each request on the
// slave stream is one control update; it yields exactly one result on the
// master stream. An accepted request sits in the input register, and its
// result is written to the output register when the request is processed,
// which waits while a result is held on the master side. One update per cycle
// is sustained while the master side takes results; that rate is set by the
// mode state, decided and written back with each update. While a result waits
// on the master side, the input register still takes one more request before
// the slave side stalls. Configuration writes take effect on the next cycle.

module obstacle_avoid_nav_fsm_top
  import oan_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], autonomous, emergency_stop, front_stop_zone, scan_done,
  // dist_front_left, dist_front_right, dist_left, dist_right, dist_rear, 2 unused bits
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // feed_watchdog, motor_action[1:0], forward_permille[10:0], rotate_permille[10:0],
  // scan_kick, advance_sweep, center_sensor, mode[2:0], one zero bit
  output logic [31:0] m_tdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    out_valid;
  logic    fire;
  result_t res;

  oan_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.now_ms           <= s_tdata[31:0];
      in_item.autonomous       <= s_tdata[32];
      in_item.emergency_stop   <= s_tdata[33];
      in_item.front_stop_zone  <= s_tdata[34];
      in_item.scan_done        <= s_tdata[35];
      in_item.dist_front_left  <= s_tdata[45:36];
      in_item.dist_front_right <= s_tdata[55:46];
      in_item.dist_left        <= s_tdata[65:56];
      in_item.dist_right       <= s_tdata[75:66];
      in_item.dist_rear        <= s_tdata[85:76];
    end
  end

  oan_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, res.mode, res.center_sensor, res.advance_sweep,
                     res.scan_kick, res.rotate_permille, res.forward_permille,
                     res.motor_action, res.feed_watchdog};

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");
  a_fire_result: assert property (@(posedge clk) disable iff (rst) fire |=> m_tvalid)
    else $error("processed request gave no result");
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted request was lost");
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[30:28] <= 3'd4))
    else $error("mode out of range");
  a_idle_speed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] != ACT_DRIVE) |-> (m_tdata[24:3] == 22'd0))
    else $error("speed set without drive action");
`endif

endmodule
